### hw/rtl/cli_pkg.sv
// Shared widths, item types and helpers for the circle/line intersection block.
// No dependencies; every other file imports this package.
package cli_pkg;

  // Coordinate width, signed Q16.16, and radius width, unsigned Q15.16
  localparam int CW    = 32;
  localparam int RW    = CW - 1;
  // Line direction, determinant and squared length
  localparam int DW    = CW + 2;
  localparam int DETW  = 2 * CW + 3;
  localparam int DR2W  = 2 * DW;
  // Multiplier operand width, product width and bits retired per stage
  localparam int MW      = DR2W;
  localparam int PW      = 2 * MW;
  localparam int MSTEP   = 8;
  localparam int MUL_LAT = (MW + MSTEP - 1) / MSTEP;
  // Signed discriminant, its non-negative part and its root
  localparam int DSW      = 2 * DETW - 2;
  localparam int DISCW    = DSW - 2;
  localparam int RTW      = DISCW / 2;
  localparam int SQRT_LAT = RTW;
  // Numerator magnitude and rounded quotient
  localparam int NW      = 3 * CW + 4;
  localparam int QW      = NW + 1;
  localparam int DIV_LAT = NW + 1;
  // Queue between front and back
  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

  typedef enum logic [1:0] {
    CLS_MISS,
    CLS_TANGENT,
    CLS_SECANT,
    CLS_DEGEN
  } cls_t;

  // One classified word handed from front to back
  typedef struct packed {
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic signed [DETW-1:0] det;
    logic [DR2W-1:0]        dr2;
    logic [DISCW-1:0]       disc;
    cls_t                   cls;
  } job_t;

  // Magnitude of a sign-extended value
  function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
    logic [MW-1:0] m;
    m = v[MW-1] ? MW'(-v) : MW'(v);
    return m;
  endfunction

endpackage

### hw/rtl/cli_mul.sv
// Pipelined unsigned multiplier, MW x MW bits, MSTEP multiplier bits per stage.
// Depends on cli_pkg; every stage advances only while en is high.
module cli_mul import cli_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] a,
  input  logic [MW-1:0] b,
  output logic [PW-1:0] p
);

  logic [PW-1:0] acc [MUL_LAT];
  logic [MW-1:0] aq  [MUL_LAT-1];
  logic [MW-1:0] bq  [MUL_LAT-1];

  for (genvar k = 0; k < MUL_LAT; k++) begin : g_stage
    logic [MW+MSTEP-1:0] pp;
    if (k == 0) begin : g_first
      assign pp = a * b[MSTEP-1:0];
      // start the sum with the lowest digit
      always_ff @(posedge clk) begin
        if (en) begin
          acc[0] <= PW'(pp);
          aq[0]  <= a;
          bq[0]  <= b >> MSTEP;
        end
      end
    end else begin : g_next
      assign pp = aq[k-1] * bq[k-1][MSTEP-1:0];
      // add the next shifted partial product
      always_ff @(posedge clk) begin
        if (en) begin
          acc[k] <= acc[k-1] + (PW'(pp) << (MSTEP * k));
        end
      end
      if (k < MUL_LAT - 1) begin : g_pass
        always_ff @(posedge clk) begin
          if (en) begin
            aq[k] <= aq[k-1];
            bq[k] <= bq[k-1] >> MSTEP;
          end
        end
      end
    end
  end

  assign p = acc[MUL_LAT-1];

endmodule

### hw/rtl/cli_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor of the root).
// Depends on cli_pkg; every stage advances only while en is high.
module cli_sqrt import cli_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DISCW-1:0] rad,
  output logic [RTW-1:0]   root
);

  localparam int RMW = RTW + 2;

  logic [RMW-1:0]   remq [RTW-1];
  logic [RTW-1:0]   rtq  [RTW];
  logic [DISCW-1:0] radq [RTW-1];

  for (genvar j = 0; j < RTW; j++) begin : g_stage
    logic [RMW-1:0]   rem_i;
    logic [RMW-1:0]   trial;
    logic [RTW-1:0]   rt_i;
    logic [DISCW-1:0] rad_i;
    logic             ge;
    if (j == 0) begin : g_first
      assign rad_i = rad;
      assign rt_i  = '0;
      assign rem_i = RMW'(rad[DISCW-1 -: 2]);
    end else begin : g_next
      assign rad_i = radq[j-1];
      assign rt_i  = rtq[j-1];
      assign rem_i = {remq[j-1][RMW-3:0], rad_i[DISCW-1 -: 2]};
    end
    assign trial = {rt_i, 2'b01};
    assign ge    = rem_i >= trial;

    // decide one root bit
    always_ff @(posedge clk) begin
      if (en) begin
        rtq[j] <= {rt_i[RTW-2:0], ge};
      end
    end
    if (j < RTW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          remq[j] <= ge ? rem_i - trial : rem_i;
          radq[j] <= rad_i << 2;
        end
      end
    end
  end

  assign root = rtq[RTW-1];

endmodule

### hw/rtl/cli_div.sv
// Pipelined restoring divider, one quotient bit per stage, then round half up
// on the magnitude. Depends on cli_pkg; every stage advances only while en is high.
module cli_div import cli_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   num,
  input  logic [DR2W-1:0] den,
  output logic [QW-1:0]   quo
);

  logic [DR2W-1:0] remq [NW];
  logic [NW-1:0]   nqq  [NW];
  logic [DR2W-1:0] dq   [NW];

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic [DR2W:0]   rem_s;
    logic [DR2W-1:0] rem_i;
    logic [DR2W-1:0] d_i;
    logic [NW-1:0]   nq_i;
    logic            ge;
    if (j == 0) begin : g_first
      assign rem_i = '0;
      assign d_i   = den;
      assign nq_i  = num;
    end else begin : g_next
      assign rem_i = remq[j-1];
      assign d_i   = dq[j-1];
      assign nq_i  = nqq[j-1];
    end
    assign rem_s = {rem_i, nq_i[NW-1]};
    assign ge    = rem_s >= {1'b0, d_i};

    // shift in one numerator bit, subtract when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        remq[j] <= ge ? DR2W'(rem_s - {1'b0, d_i}) : rem_s[DR2W-1:0];
        nqq[j]  <= {nq_i[NW-2:0], ge};
        dq[j]   <= d_i;
      end
    end
  end

  // round to nearest, ties away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= QW'(nqq[NW-1]) +
             QW'({remq[NW-1], 1'b0} >= {1'b0, dq[NW-1]});
    end
  end

endmodule

### hw/rtl/cli_front.sv
// Front end: accept a query, form direction, |d|^2, determinant and the
// discriminant, classify. Depends on cli_pkg and cli_mul.
module cli_front import cli_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] center_x,
  input  logic signed [CW-1:0] center_y,
  input  logic [RW-1:0]        radius,
  input  logic signed [CW-1:0] first_x,
  input  logic signed [CW-1:0] first_y,
  input  logic signed [CW-1:0] second_x,
  input  logic signed [CW-1:0] second_y,
  input  logic                 full,
  output logic                 push,
  output job_t                 job
);

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [RW-1:0]        r;
    logic                 sa;
    logic                 sb;
  } fp_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } sp_t;

  logic en;
  assign en       = !full;
  assign in_stall = full;

  // shift line points by the center
  logic signed [CW:0]   x1_c, y1_c, x2_c, y2_c;
  logic signed [DW-1:0] dx_c, dy_c;
  assign x1_c = (CW+1)'(first_x) - (CW+1)'(center_x);
  assign y1_c = (CW+1)'(first_y) - (CW+1)'(center_y);
  assign x2_c = (CW+1)'(second_x) - (CW+1)'(center_x);
  assign y2_c = (CW+1)'(second_y) - (CW+1)'(center_y);
  assign dx_c = DW'(second_x) - DW'(first_x);
  assign dy_c = DW'(second_y) - DW'(first_y);

  // input stage
  logic               v0;
  logic signed [CW:0] x1, y1, x2, y2;
  fp_t                pay0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1      <= x1_c;
      y1      <= y1_c;
      x2      <= x2_c;
      y2      <= y2_c;
      pay0.cx <= center_x;
      pay0.cy <= center_y;
      pay0.dx <= dx_c;
      pay0.dy <= dy_c;
      pay0.r  <= radius;
      pay0.sa <= x1_c[CW] ^ y2_c[CW];
      pay0.sb <= x2_c[CW] ^ y1_c[CW];
    end
  end

  // first product round: dx^2, dy^2, x1*y2, x2*y1, r^2
  logic [PW-1:0] pdx, pdy, pa, pb, pr;

  cli_mul u_mdx (.clk, .en, .a(mag(MW'(pay0.dx))), .b(mag(MW'(pay0.dx))), .p(pdx));
  cli_mul u_mdy (.clk, .en, .a(mag(MW'(pay0.dy))), .b(mag(MW'(pay0.dy))), .p(pdy));
  cli_mul u_ma  (.clk, .en, .a(mag(MW'(x1))), .b(mag(MW'(y2))), .p(pa));
  cli_mul u_mb  (.clk, .en, .a(mag(MW'(x2))), .b(mag(MW'(y1))), .p(pb));
  cli_mul u_mr  (.clk, .en, .a(MW'(pay0.r)), .b(MW'(pay0.r)), .p(pr));

  // carry the item alongside the first multipliers
  fp_t  dl1 [MUL_LAT];
  logic vd1 [MUL_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MUL_LAT; k++) vd1[k] <= 1'b0;
    end else if (en) begin
      vd1[0] <= v0;
      for (int k = 1; k < MUL_LAT; k++) vd1[k] <= vd1[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl1[0] <= pay0;
      for (int k = 1; k < MUL_LAT; k++) dl1[k] <= dl1[k-1];
    end
  end

  // combine: |d|^2 and determinant
  logic signed [DETW-1:0] ta, tb, det_c;
  assign ta    = $signed(DETW'(pa[2*CW:0]));
  assign tb    = $signed(DETW'(pb[2*CW:0]));
  assign det_c = (dl1[MUL_LAT-1].sa ? -ta : ta) - (dl1[MUL_LAT-1].sb ? -tb : tb);

  logic                   v2;
  logic [DR2W-1:0]        dr2;
  logic signed [DETW-1:0] det;
  logic [2*RW-1:0]        rr;
  sp_t                    pay2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= vd1[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr2     <= pdx[DR2W-1:0] + pdy[DR2W-1:0];
      det     <= det_c;
      rr      <= pr[2*RW-1:0];
      pay2.cx <= dl1[MUL_LAT-1].cx;
      pay2.cy <= dl1[MUL_LAT-1].cy;
      pay2.dx <= dl1[MUL_LAT-1].dx;
      pay2.dy <= dl1[MUL_LAT-1].dy;
    end
  end

  // second product round: r^2*|d|^2 and det^2
  logic [PW-1:0] prd, pdd;

  cli_mul u_mrd (.clk, .en, .a(MW'(rr)), .b(dr2), .p(prd));
  cli_mul u_mdd (.clk, .en, .a(mag(MW'(det))), .b(mag(MW'(det))), .p(pdd));

  typedef struct packed {
    sp_t                    sp;
    logic [DR2W-1:0]        dr2;
    logic signed [DETW-1:0] det;
  } tp_t;

  tp_t  dl2 [MUL_LAT];
  logic vd2 [MUL_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MUL_LAT; k++) vd2[k] <= 1'b0;
    end else if (en) begin
      vd2[0] <= v2;
      for (int k = 1; k < MUL_LAT; k++) vd2[k] <= vd2[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl2[0] <= '{sp: pay2, dr2: dr2, det: det};
      for (int k = 1; k < MUL_LAT; k++) dl2[k] <= dl2[k-1];
    end
  end

  // discriminant and class
  logic signed [DSW-1:0] disc_c;
  job_t                  job_c;
  tp_t                   t2;

  assign t2     = dl2[MUL_LAT-1];
  assign disc_c = $signed({1'b0, prd[DSW-2:0]}) - $signed({1'b0, pdd[DSW-2:0]});

  always_comb begin
    job_c.cx   = t2.sp.cx;
    job_c.cy   = t2.sp.cy;
    job_c.dx   = t2.sp.dx;
    job_c.dy   = t2.sp.dy;
    job_c.det  = t2.det;
    job_c.dr2  = t2.dr2;
    job_c.disc = disc_c[DSW-1] ? '0 : disc_c[DISCW-1:0];
    if (t2.dr2 == '0) begin
      job_c.cls = CLS_DEGEN;
    end else if (disc_c[DSW-1]) begin
      job_c.cls = CLS_MISS;
    end else if (disc_c == '0) begin
      job_c.cls = CLS_TANGENT;
    end else begin
      job_c.cls = CLS_SECANT;
    end
  end

  logic v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vd2[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job <= job_c;
    end
  end

  // hand the word to the queue
  assign push = v3 && en;

endmodule

### hw/rtl/cli_fifo.sv
// Short queue of classified words between front and back.
// Depends on cli_pkg.
module cli_fifo import cli_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  job_t           mem [QD];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   cnt;

  assign full  = cnt == (QAW+1)'(QD);
  assign empty = cnt == '0;
  assign rdata = mem[rp];

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  // store the word
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

endmodule

### hw/rtl/cli_back.sv
// Back end: square root, numerators, four rounded divisions, center offset
// and clipping into the output register. Depends on cli_pkg, cli_mul,
// cli_sqrt and cli_div.
module cli_back import cli_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  job_t                 job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           hit_count,
  output logic signed [CW-1:0] hit0_x,
  output logic signed [CW-1:0] hit0_y,
  output logic signed [CW-1:0] hit1_x,
  output logic signed [CW-1:0] hit1_y,
  output logic                 degenerate,
  output logic                 saturated
);

  typedef struct packed {
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic signed [DETW-1:0] det;
    logic [DR2W-1:0]        dr2;
    cls_t                   cls;
  } bp_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [3:0]           neg;
    cls_t                 cls;
  } ep_t;

  localparam int SW = QW + 2;
  localparam logic signed [SW-1:0] SMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic en;
  assign en  = !(out_valid && out_stall);
  assign pop = en && !empty;

  // take a word from the queue
  logic v0;
  job_t j0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) j0 <= job;
  end

  // root of the discriminant
  logic [RTW-1:0] root;

  cli_sqrt u_sqrt (.clk, .en, .rad(j0.disc), .root);

  bp_t  d1  [SQRT_LAT];
  logic vd1 [SQRT_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_LAT; k++) vd1[k] <= 1'b0;
    end else if (en) begin
      vd1[0] <= v0;
      for (int k = 1; k < SQRT_LAT; k++) vd1[k] <= vd1[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= '{cx: j0.cx, cy: j0.cy, dx: j0.dx, dy: j0.dy,
                 det: j0.det, dr2: j0.dr2, cls: j0.cls};
      for (int k = 1; k < SQRT_LAT; k++) d1[k] <= d1[k-1];
    end
  end

  // products det*dy, det*dx, dx*s, dy*s
  bp_t           e1;
  logic [PW-1:0] p1, p2, t1, t2;
  assign e1 = d1[SQRT_LAT-1];

  cli_mul u_mp1 (.clk, .en, .a(mag(MW'(e1.det))), .b(mag(MW'(e1.dy))), .p(p1));
  cli_mul u_mp2 (.clk, .en, .a(mag(MW'(e1.det))), .b(mag(MW'(e1.dx))), .p(p2));
  cli_mul u_mt1 (.clk, .en, .a(mag(MW'(e1.dx))), .b(MW'(root)), .p(t1));
  cli_mul u_mt2 (.clk, .en, .a(mag(MW'(e1.dy))), .b(MW'(root)), .p(t2));

  bp_t  d2  [MUL_LAT];
  logic vd2 [MUL_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MUL_LAT; k++) vd2[k] <= 1'b0;
    end else if (en) begin
      vd2[0] <= vd1[SQRT_LAT-1];
      for (int k = 1; k < MUL_LAT; k++) vd2[k] <= vd2[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2[0] <= e1;
      for (int k = 1; k < MUL_LAT; k++) d2[k] <= d2[k-1];
    end
  end

  // signed numerators for both points
  bp_t                  e2;
  logic signed [NW:0]   px, py, tx, ty;
  logic signed [NW:0]   nsum [4];
  logic                 sdet, sdx, sdy;
  assign e2   = d2[MUL_LAT-1];
  assign sdet = e2.det[DETW-1];
  assign sdx  = e2.dx[DW-1];
  assign sdy  = e2.dy[DW-1];

  always_comb begin
    px = $signed({1'b0, p1[NW-1:0]});
    py = $signed({1'b0, p2[NW-1:0]});
    tx = $signed({1'b0, t1[NW-1:0]});
    ty = $signed({1'b0, t2[NW-1:0]});
    if (sdet ^ sdy)    px = -px;
    if (!(sdet ^ sdx)) py = -py;
    if (sdx ^ sdy)     tx = -tx;
    nsum[0] = px + tx;
    nsum[1] = py + ty;
    nsum[2] = px - tx;
    nsum[3] = py - ty;
  end

  logic            v2;
  logic [NW-1:0]   nm [4];
  logic [DR2W-1:0] dr2;
  ep_t             ep2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= vd2[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        nm[i]      <= nsum[i][NW] ? NW'(-nsum[i]) : nsum[i][NW-1:0];
        ep2.neg[i] <= nsum[i][NW];
      end
      dr2     <= e2.dr2;
      ep2.cx  <= e2.cx;
      ep2.cy  <= e2.cy;
      ep2.cls <= e2.cls;
    end
  end

  // four rounded divisions by |d|^2
  logic [QW-1:0] quo [4];

  for (genvar i = 0; i < 4; i++) begin : g_div
    cli_div u_div (.clk, .en, .num(nm[i]), .den(dr2), .quo(quo[i]));
  end

  ep_t  d3  [DIV_LAT];
  logic vd3 [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) vd3[k] <= 1'b0;
    end else if (en) begin
      vd3[0] <= v2;
      for (int k = 1; k < DIV_LAT; k++) vd3[k] <= vd3[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3[0] <= ep2;
      for (int k = 1; k < DIV_LAT; k++) d3[k] <= d3[k-1];
    end
  end

  // apply sign, add center, clip
  ep_t                  e3;
  logic signed [QW:0]   qs   [4];
  logic signed [SW-1:0] sum  [4];
  logic [CW-1:0]        val  [4];
  logic [3:0]           clip;
  assign e3 = d3[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qs[i]  = $signed({1'b0, quo[i]});
      if (e3.neg[i]) qs[i] = -qs[i];
      sum[i] = SW'(qs[i]) + ((i % 2 == 0) ? SW'(e3.cx) : SW'(e3.cy));
      if (sum[i] > SMAX) begin
        val[i]  = SMAX[CW-1:0];
        clip[i] = 1'b1;
      end else if (sum[i] < SMIN) begin
        val[i]  = SMIN[CW-1:0];
        clip[i] = 1'b1;
      end else begin
        val[i]  = sum[i][CW-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  // pick the reported fields by class
  logic [1:0]           hit_count_next;
  logic signed [CW-1:0] hit0_x_next, hit0_y_next, hit1_x_next, hit1_y_next;
  logic                 degenerate_next, saturated_next;

  always_comb begin
    hit_count_next  = 2'd0;
    hit0_x_next     = '0;
    hit0_y_next     = '0;
    hit1_x_next     = '0;
    hit1_y_next     = '0;
    degenerate_next = 1'b0;
    saturated_next  = 1'b0;
    case (e3.cls)
      CLS_DEGEN: begin
        degenerate_next = 1'b1;
      end
      CLS_TANGENT: begin
        hit_count_next = 2'd1;
        hit0_x_next    = val[0];
        hit0_y_next    = val[1];
        saturated_next = clip[0] | clip[1];
      end
      CLS_SECANT: begin
        hit_count_next = 2'd2;
        hit0_x_next    = val[0];
        hit0_y_next    = val[1];
        hit1_x_next    = val[2];
        hit1_y_next    = val[3];
        saturated_next = |clip;
      end
      default: begin
        hit_count_next = 2'd0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd3[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_count  <= hit_count_next;
      hit0_x     <= hit0_x_next;
      hit0_y     <= hit0_y_next;
      hit1_x     <= hit1_x_next;
      hit1_y     <= hit1_y_next;
      degenerate <= degenerate_next;
      saturated  <= saturated_next;
    end
  end

  // a degenerate query (both line points equal) reports no points
  a_degen_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> hit_count == 2'd0)
    else $error("degenerate result with points");

  // clipping only comes from a reported point
  a_sat_has_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> hit_count != 2'd0)
    else $error("saturated flag without points");

  // second point is zero unless two points were found
  a_hit1_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_count != 2'd2 |-> hit1_x == '0 && hit1_y == '0)
    else $error("second point set without two hits");

  // a held result does not move the pipeline
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> !$past(pop))
    else $error("queue popped while output held");

endmodule

### hw/rtl/circle_line_intersection_top.sv
// Channel   Handshake               Word
// in        in_valid / in_stall     center_x, center_y, radius, first_*, second_*
// out       out_valid / out_stall   hit_count, hit0_*, hit1_*, degenerate, saturated
//
// Takes one query per cycle while in_stall is low. The back end holds most of
// the pipeline: a 65-stage square root, a 9-stage multiplier round and four
// 101-stage dividers; the front adds two 9-stage multiplier rounds.
// Reset (rst, synchronous) empties the pipelines and the 4-word queue.
// A held output freezes the back end; the queue then fills and in_stall rises.
// Top level: cli_front, cli_fifo, cli_back; depends on cli_pkg.
module circle_line_intersection_top import cli_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] center_x,
  input  logic signed [CW-1:0] center_y,
  input  logic [RW-1:0]        radius,
  input  logic signed [CW-1:0] first_x,
  input  logic signed [CW-1:0] first_y,
  input  logic signed [CW-1:0] second_x,
  input  logic signed [CW-1:0] second_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           hit_count,
  output logic signed [CW-1:0] hit0_x,
  output logic signed [CW-1:0] hit0_y,
  output logic signed [CW-1:0] hit1_x,
  output logic signed [CW-1:0] hit1_y,
  output logic                 degenerate,
  output logic                 saturated
);

  logic push, pop, full, empty;
  job_t wjob, rjob;

  // classify incoming queries
  cli_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .center_x, .center_y, .radius, .first_x, .first_y, .second_x, .second_y,
    .full, .push, .job(wjob)
  );

  // decouple front and back
  cli_fifo u_fifo (
    .clk, .rst, .push, .wdata(wjob), .full, .pop, .rdata(rjob), .empty
  );

  // compute the points
  cli_back u_back (
    .clk, .rst, .empty, .job(rjob), .pop,
    .out_valid, .out_stall, .hit_count, .hit0_x, .hit0_y, .hit1_x, .hit1_y,
    .degenerate, .saturated
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for circle_line_intersection_top: exact wide-integer
// prediction of hit points, scoreboard class, random valid/stall traffic.
// Depends on cli_pkg and the RTL of the block.
module testbench;
  import cli_pkg::*;

  localparam int NUM_RANDOM  = 650;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 250;
  localparam int LONG_HOLD   = 400;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] cx, cy;
    logic [RW-1:0]        r;
    logic signed [CW-1:0] fx, fy, sx, sy;
  } query_t;

  typedef struct packed {
    logic [1:0]           count;
    logic signed [CW-1:0] h0x, h0y, h1x, h1y;
    logic                 deg, sat;
  } hits_t;

  // Predicts hit points per query and checks them in order
  class hit_scoreboard;
    hits_t hits_q[$];
    int    mismatches = 0;
    int    n_miss = 0, n_tan = 0, n_sec = 0, n_deg = 0, n_sat = 0;
    bit    clip;

    function wide_t isqrt(wide_t v);
      wide_t root, cand;
      root = '0;
      for (int i = 127; i >= 0; i--) begin
        cand = root | (wide_t'(1) << i);
        if (cand * cand <= v) root = cand;
      end
      return root;
    endfunction

    // Round to nearest, ties away from zero
    function wide_t round_div(wide_t n, wide_t d);
      wide_t m, qv, rm;
      m = (n < 0) ? -n : n;
      qv = m / d;
      rm = m % d;
      if (rm * 2 >= d) qv = qv + 1;
      return (n < 0) ? -qv : qv;
    endfunction

    function logic signed [CW-1:0] fit(wide_t v);
      wide_t hi, lo;
      hi = (wide_t'(1) << (CW - 1)) - 1;
      lo = -(wide_t'(1) << (CW - 1));
      if (v > hi) begin
        clip = 1;
        return hi[CW-1:0];
      end
      if (v < lo) begin
        clip = 1;
        return lo[CW-1:0];
      end
      return v[CW-1:0];
    endfunction

    function hits_t predict_hits(query_t q);
      wide_t cx, cy, r, x1, y1, x2, y2, dx, dy, dr2, det, disc, s, px, py, tx, ty;
      hits_t o;
      o = '0;
      clip = 0;
      cx = q.cx;
      cy = q.cy;
      r = wide_t'(q.r);
      x1 = wide_t'(q.fx) - cx;
      y1 = wide_t'(q.fy) - cy;
      x2 = wide_t'(q.sx) - cx;
      y2 = wide_t'(q.sy) - cy;
      dx = x2 - x1;
      dy = y2 - y1;
      dr2 = dx * dx + dy * dy;
      if (dr2 == 0) begin
        o.deg = 1;
        return o;
      end
      det = x1 * y2 - x2 * y1;
      disc = r * r * dr2 - det * det;
      if (disc < 0) return o;
      s = isqrt(disc);
      px = det * dy;
      py = -(det * dx);
      tx = ((dy < 0) ? -dx : dx) * s;
      ty = ((dy < 0) ? -dy : dy) * s;
      o.h0x = fit(round_div(px + tx, dr2) + cx);
      o.h0y = fit(round_div(py + ty, dr2) + cy);
      if (disc == 0) begin
        o.count = 1;
      end else begin
        o.count = 2;
        o.h1x = fit(round_div(px - tx, dr2) + cx);
        o.h1y = fit(round_div(py - ty, dr2) + cy);
      end
      o.sat = clip;
      return o;
    endfunction

    function void note_query(query_t q);
      hits_t e;
      e = predict_hits(q);
      hits_q.push_back(e);
      if (e.deg) n_deg++;
      else if (e.count == 0) n_miss++;
      else if (e.count == 1) n_tan++;
      else n_sec++;
      if (e.sat) n_sat++;
    endfunction

    function void check_hits(hits_t got);
      hits_t e;
      if (hits_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, count=%0d", got.count);
        return;
      end
      e = hits_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp cnt=%0d h0=(%0d,%0d) h1=(%0d,%0d) deg=%0b sat=%0b",
                   e.count, e.h0x, e.h0y, e.h1x, e.h1y, e.deg, e.sat);
          $display("          got cnt=%0d h0=(%0d,%0d) h1=(%0d,%0d) deg=%0b sat=%0b",
                   got.count, got.h0x, got.h0y, got.h1x, got.h1y, got.deg, got.sat);
        end
      end
    endfunction

    function int pending();
      return hits_q.size();
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic signed [CW-1:0] center_x = '0, center_y = '0;
  logic [RW-1:0]        radius = '0;
  logic signed [CW-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  logic [1:0]           hit_count;
  logic signed [CW-1:0] hit0_x, hit0_y, hit1_x, hit1_y;
  logic                 degenerate, saturated;

  hit_scoreboard sb = new();
  query_t directed_q[$];
  bit     hold_req = 0;
  int     idle_cycles = 0;

  circle_line_intersection_top u_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Note accepted queries, check accepted results
  always @(posedge clk) begin
    hits_t got;
    if (!rst && in_valid && !in_stall)
      sb.note_query('{center_x, center_y, radius, first_x, first_y, second_x, second_y});
    if (!rst && out_valid && !out_stall) begin
      got = '{hit_count, hit0_x, hit0_y, hit1_x, hit1_y, degenerate, saturated};
      sb.check_hits(got);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: random stall per word, plus one long hold on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_stall <= 1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
      end
      n = $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic signed [CW-1:0] rnd32();
    return $signed($urandom());
  endfunction

  // Random query: full range, near the circle, degenerate, or tangent
  function automatic query_t make_query();
    query_t q;
    longint c0, c1, rr, span;
    int     kind;
    kind = $urandom_range(0, 9);
    q = '{rnd32(), rnd32(), RW'($urandom()), rnd32(), rnd32(), rnd32(), rnd32()};
    if (kind >= 2) begin
      c0 = $signed($urandom()) >>> 3;
      c1 = $signed($urandom()) >>> 3;
      rr = (kind < 8) ? $urandom_range(0, 1 << 22) : $urandom_range(0, 1 << 27);
      span = 2 * rr + 2;
      q.cx = CW'(c0);
      q.cy = CW'(c1);
      q.r = RW'(rr);
      q.fx = CW'(c0 + longint'($urandom_range(0, 2 * span)) - span);
      q.fy = CW'(c1 + longint'($urandom_range(0, 2 * span)) - span);
      q.sx = CW'(c0 + longint'($urandom_range(0, 2 * span)) - span);
      q.sy = CW'(c1 + longint'($urandom_range(0, 2 * span)) - span);
      if (kind == 7) begin
        q.sy = CW'(c1 + rr);
        q.fy = CW'(c1 + rr);
      end
    end
    if (kind == 1) begin
      q.sx = q.fx;
      q.sy = q.fy;
    end
    return q;
  endfunction

  // Drive one query and hold it until accepted
  task automatic send_query(query_t q, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    center_x <= q.cx;
    center_y <= q.cy;
    radius <= q.r;
    first_x <= q.fx;
    first_y <= q.fy;
    second_x <= q.sx;
    second_y <= q.sy;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE  = 1 <<< 16;
    localparam logic [RW-1:0]        MAXR = '1;
    int gap;
    bit burst;

    // Zero query, extremes, tangents, secants, vertical, reversed, clipping
    directed_q = '{
      '{0, 0, 0, 0, 0, 0, 0},
      '{MAXC, MAXC, MAXR, MAXC, MAXC, MAXC, MAXC},
      '{MINC, MINC, 0, MINC, MINC, MINC, MINC},
      '{0, 0, MAXR, MINC, MINC, MAXC, MAXC},
      '{0, 0, MAXR, MINC, MAXC, MAXC, MINC},
      '{MINC, MAXC, MAXR, MAXC, MINC, MINC, MAXC},
      '{0, 0, ONE, -ONE, ONE, ONE, ONE},
      '{0, 0, ONE, ONE, -ONE, ONE, ONE},
      '{5 * ONE, -3 * ONE, 0, 4 * ONE, -4 * ONE, 6 * ONE, -2 * ONE},
      '{0, 0, ONE, -2 * ONE, 0, 2 * ONE, 0},
      '{0, 0, ONE, 0, 2 * ONE, 0, -2 * ONE},
      '{0, 0, ONE, 3 * ONE, 2 * ONE, -1 * ONE, -5 * ONE},
      '{0, 0, ONE, 3 * ONE, 3 * ONE, 4 * ONE, 3 * ONE},
      '{MAXC, MAXC, MAXR, 0, 0, ONE, 0},
      '{MINC, MINC, MAXR, 0, 0, 0, ONE},
      '{MAXC, 0, 10 * ONE, MAXC, 5, MAXC - 7, -9},
      '{7, 9, 3, 7, 9, 7, 9},
      '{0, 0, 2, 1, 1, -1, -1},
      '{MINC, MAXC, 1, MINC, MAXC, MINC + 1, MAXC}
    };

    repeat (8) @(posedge clk);
    rst <= 0;

    foreach (directed_q[i]) send_query(directed_q[i], $urandom_range(0, 2));

    burst = 0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 80 == 0) burst = $urandom_range(0, 2) == 0;
      if (i == 250) begin
        in_valid <= 0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      if (i == 450) hold_req = 1;
      gap = burst ? 0 : $urandom_range(0, 5);
      send_query(make_query(), gap);
    end
    in_valid <= 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d misses, %0d tangents, %0d secants, %0d degenerate lines",
             sb.n_miss, sb.n_tan, sb.n_sec, sb.n_deg);
    $display("%0d results clipped, %0d mismatches", sb.n_sat, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
